FILE: design/isp_pkg.sv
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types and constants of the serial IMU frame parser: frame geometry,
// frame kind and status codes, and configuration register indexes.
// ----------------------------------------------------------------------------
package isp_pkg;

    // Frame geometry: start, type, eight data bytes, checksum.
    localparam int FRAME_BYTES = 11;
    localparam int STORE_DEPTH = FRAME_BYTES - 2;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_TYPE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_TYPE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_TYPE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TYPE = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_START_BYTE = 8'd85;
    localparam logic [7:0] RST_TIME_TYPE  = 8'd80;
    localparam logic [7:0] RST_ACCEL_TYPE = 8'd81;
    localparam logic [7:0] RST_RATE_TYPE  = 8'd82;
    localparam logic [7:0] RST_ANGLE_TYPE = 8'd83;

    // Kind of a completed frame.
    typedef enum logic [2:0] {
        KIND_ACCEL   = 3'd0,
        KIND_RATE    = 3'd1,
        KIND_ANGLE   = 3'd2,
        KIND_TIME    = 3'd3,
        KIND_UNKNOWN = 3'd4
    } t_kind;

    // Status of a completed frame.
    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_BAD_SUM = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    // What the configuration block hands to the frame logic.
    typedef struct packed {
        logic [7:0] start_byte;
        t_kind      kind;
    } t_cfg_view;

endpackage

FILE: design/imu_serial_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_serial_frame_parser
// Hunts for a start byte in a stream of received serial bytes, collects an
// eleven-byte frame, checks its additive checksum and reports one result
// per frame: kind, status and four little-endian signed words.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                          Request
//  rx        in         i_rx_valid / o_rx_ready          one received byte
//  res       out        o_res_valid / i_res_ready        one decoded frame
//  cfg       in         i_cfg_we, i_cfg_index, data      register write
//
//  One byte is taken per cycle unless the checksum byte stalls; a frame's
//  result is registered and appears the cycle after that byte is accepted.
//  Only the checksum byte waits on the result register: a stalled result
//  holds back that byte alone, all other bytes keep flowing.
//  Reset (synchronous, active low) returns to hunting, drops any pending
//  result and restores the register defaults.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Received bytes.
    input  logic                           i_rx_valid,
    output logic                           o_rx_ready,
    input  logic [7:0]                     i_rx_byte,
    // Decoded frames.
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output logic [2:0]                     o_frame_kind,
    output logic [1:0]                     o_frame_status,
    output logic signed [15:0]             o_axis_x,
    output logic signed [15:0]             o_axis_y,
    output logic signed [15:0]             o_axis_z,
    output logic signed [15:0]             o_temp_raw,
    // Configuration writes.
    input  logic                           i_cfg_we,
    input  logic [isp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [isp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [isp_pkg::POS_W-1:0] POS_LAST =
        isp_pkg::POS_W'(isp_pkg::FRAME_BYTES - 1);

    logic [isp_pkg::POS_W-1:0] r_pos;
    logic [isp_pkg::POS_W-1:0] n_pos;
    logic [7:0]                r_sum;
    logic [7:0]                n_sum;
    logic [7:0]                r_store [isp_pkg::STORE_DEPTH];
    logic                      r_res_valid;
    logic                      n_res_valid;

    logic [2:0]         r_kind;
    logic [1:0]         r_status;
    logic signed [15:0] r_axis_x;
    logic signed [15:0] r_axis_y;
    logic signed [15:0] r_axis_z;
    logic signed [15:0] r_temp;

    isp_pkg::t_cfg_view         cfg_view;
    isp_pkg::t_status           frame_status;
    logic                       pos_last;
    logic                       rx_accept;
    logic                       frame_done;
    logic [isp_pkg::STORE_IDX_W-1:0] store_idx;

    // Configuration registers and type classification.
    isp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_type_byte (r_store[0]),
        .o_cfg       (cfg_view)
    );

    // Handshake: only the checksum byte needs room in the result register.
    assign pos_last   = (r_pos >= POS_LAST);
    assign o_rx_ready = !pos_last || !r_res_valid || i_res_ready;
    assign rx_accept  = i_rx_valid && o_rx_ready;
    assign frame_done = rx_accept && pos_last;
    assign store_idx  = isp_pkg::STORE_IDX_W'(r_pos - isp_pkg::POS_W'(1));

    // Frame status: ignored types skip the checksum test.
    always_comb begin
        if (cfg_view.kind == isp_pkg::KIND_TIME || cfg_view.kind == isp_pkg::KIND_UNKNOWN) begin
            frame_status = isp_pkg::ST_IGNORED;
        end else if (r_sum != i_rx_byte) begin
            frame_status = isp_pkg::ST_BAD_SUM;
        end else begin
            frame_status = isp_pkg::ST_VALID;
        end
    end

    // Next position, running sum and result valid.
    always_comb begin
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_res_valid = r_res_valid && !i_res_ready;
        if (rx_accept) begin
            if (r_pos == '0) begin
                if (i_rx_byte == cfg_view.start_byte) begin
                    n_pos = isp_pkg::POS_W'(1);
                    n_sum = i_rx_byte;
                end
            end else if (!pos_last) begin
                n_pos = r_pos + isp_pkg::POS_W'(1);
                n_sum = r_sum + i_rx_byte;
            end else begin
                n_pos       = '0;
                n_sum       = '0;
                n_res_valid = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_res_valid <= n_res_valid;
        end
    end

    // Frame store: type byte and the eight data bytes.
    always_ff @(posedge i_clk) begin
        if (rx_accept && r_pos != '0 && !pos_last) begin
            r_store[store_idx] <= i_rx_byte;
        end
    end

    // Result register; words are cleared unless the frame is valid.
    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            r_kind   <= cfg_view.kind;
            r_status <= frame_status;
            if (frame_status == isp_pkg::ST_VALID) begin
                r_axis_x <= {r_store[2], r_store[1]};
                r_axis_y <= {r_store[4], r_store[3]};
                r_axis_z <= {r_store[6], r_store[5]};
                r_temp   <= {r_store[8], r_store[7]};
            end else begin
                r_axis_x <= '0;
                r_axis_y <= '0;
                r_axis_z <= '0;
                r_temp   <= '0;
            end
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_frame_kind   = r_kind;
    assign o_frame_status = r_status;
    assign o_axis_x       = r_axis_x;
    assign o_axis_y       = r_axis_y;
    assign o_axis_z       = r_axis_z;
    assign o_temp_raw     = r_temp;

    // A valid frame is always one of the three measurement kinds.
    a_valid_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_frame_status == isp_pkg::ST_VALID)
            |-> (o_frame_kind == isp_pkg::KIND_ACCEL || o_frame_kind == isp_pkg::KIND_RATE
                 || o_frame_kind == isp_pkg::KIND_ANGLE))
        else $error("valid frame with a non-measurement kind");

    // Words of a frame that is not valid are zero.
    a_zero_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_frame_status != isp_pkg::ST_VALID)
            |-> (o_axis_x == '0 && o_axis_y == '0 && o_axis_z == '0 && o_temp_raw == '0))
        else $error("non-valid frame carries data words");

    // The position never passes the checksum byte.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("byte position beyond the frame");

    // A checksum byte always opens a fresh hunt and raises a result.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_done |=> (r_pos == '0 && r_res_valid))
        else $error("frame end did not produce a result");

    // While hunting, a byte other than the start byte is dropped.
    a_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_accept && r_pos == '0 && i_rx_byte != cfg_view.start_byte && !i_cfg_we)
            |=> r_pos == '0)
        else $error("frame opened without a start byte");

endmodule

FILE: design/isp_cfg_regs.sv
// ----------------------------------------------------------------------------
// isp_cfg_regs
// Configuration registers of the frame parser and the type classifier that
// maps a frame's type byte onto a frame kind.
// ----------------------------------------------------------------------------
module isp_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [isp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [isp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]                     i_type_byte,
    output isp_pkg::t_cfg_view             o_cfg
);

    logic [7:0] r_start_byte;
    logic [7:0] r_time_type;
    logic [7:0] r_accel_type;
    logic [7:0] r_rate_type;
    logic [7:0] r_angle_type;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= isp_pkg::RST_START_BYTE;
            r_time_type  <= isp_pkg::RST_TIME_TYPE;
            r_accel_type <= isp_pkg::RST_ACCEL_TYPE;
            r_rate_type  <= isp_pkg::RST_RATE_TYPE;
            r_angle_type <= isp_pkg::RST_ANGLE_TYPE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                isp_pkg::CFG_START_BYTE: r_start_byte <= i_cfg_data[7:0];
                isp_pkg::CFG_TIME_TYPE:  r_time_type  <= i_cfg_data[7:0];
                isp_pkg::CFG_ACCEL_TYPE: r_accel_type <= i_cfg_data[7:0];
                isp_pkg::CFG_RATE_TYPE:  r_rate_type  <= i_cfg_data[7:0];
                isp_pkg::CFG_ANGLE_TYPE: r_angle_type <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Classify the type byte; on colliding codes the first match wins.
    always_comb begin
        o_cfg.start_byte = r_start_byte;
        if (i_type_byte == r_accel_type) begin
            o_cfg.kind = isp_pkg::KIND_ACCEL;
        end else if (i_type_byte == r_rate_type) begin
            o_cfg.kind = isp_pkg::KIND_RATE;
        end else if (i_type_byte == r_angle_type) begin
            o_cfg.kind = isp_pkg::KIND_ANGLE;
        end else if (i_type_byte == r_time_type) begin
            o_cfg.kind = isp_pkg::KIND_TIME;
        end else begin
            o_cfg.kind = isp_pkg::KIND_UNKNOWN;
        end
    end

endmodule
